[sv/kvlp_pkg.sv]
// ----------------------------------------------------------------------------
// kvlp_pkg
// Shared types and constants for the key/value line parser: parser states,
// result kinds, character codes and the records passed between the modules.
// ----------------------------------------------------------------------------
package kvlp_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned KCNT_W   = 6;
  localparam int unsigned VCNT_W   = 7;
  localparam int unsigned PEND_AW  = 6;
  localparam int unsigned PEND_DEP = 64;

  localparam logic [CHAR_W-1:0] CH_HASH = 8'h23;
  localparam logic [CHAR_W-1:0] CH_EQ   = 8'h3d;
  localparam logic [CHAR_W-1:0] CH_NL   = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_SP   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB  = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR   = 8'h0d;

  typedef enum logic [2:0] {
    ST_BLANK   = 3'd0,
    ST_COMMENT = 3'd1,
    ST_KEY     = 3'd2,
    ST_SEEK    = 3'd3,
    ST_SKIPVAL = 3'd4,
    ST_VALUE   = 3'd5,
    ST_IGNORE  = 3'd6
  } pstate_t;

  typedef enum logic [1:0] {
    K_KEY  = 2'd0,
    K_VAL  = 2'd1,
    K_DONE = 2'd2,
    K_DROP = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    SEQ_IDLE  = 2'd0,
    SEQ_FLUSH = 2'd1,
    SEQ_TAIL  = 2'd2
  } seq_t;

  typedef struct packed {
    logic              res_valid;
    kind_t             res_kind;
    logic [CHAR_W-1:0] res_chr;
    logic [VCNT_W-1:0] flush_cnt;
  } step_t;

  typedef struct packed {
    logic               we;
    logic [PEND_AW-1:0] addr;
    logic [CHAR_W-1:0]  data;
  } pwr_t;

  function automatic logic is_ws(input logic [CHAR_W-1:0] c);
    return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

[sv/kvlp_pend_mem.sv]
// ----------------------------------------------------------------------------
// kvlp_pend_mem
// Buffer for held-back trailing whitespace of a value. One write port and
// one read port with a registered read.
// ----------------------------------------------------------------------------
module kvlp_pend_mem
  import kvlp_pkg::*;
(
  input  logic               clk,
  input  pwr_t               wr,
  input  logic [PEND_AW-1:0] raddr,
  output logic [CHAR_W-1:0]  rdata
);

  logic [CHAR_W-1:0] mem [PEND_DEP];
  logic [CHAR_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/kvlp_parser.sv]
// ----------------------------------------------------------------------------
// kvlp_parser
// Record parser. Holds the parse state and the key, value and pending
// counters, and decides for each accepted request what it produces and
// which whitespace goes into the pending buffer.
// ----------------------------------------------------------------------------
module kvlp_parser
  import kvlp_pkg::*;
#(
  parameter int unsigned KEY_LEN   = 32,
  parameter int unsigned VALUE_LEN = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [CHAR_W-1:0] ch,
  input  logic              at_end,
  output step_t             step,
  output pwr_t              wr
);

  localparam logic [KCNT_W-1:0] KEY_MAX = KCNT_W'(KEY_LEN - 1);
  localparam logic [VCNT_W-1:0] VAL_MAX = VCNT_W'(VALUE_LEN - 1);

  pstate_t           st_r,  st_nxt;
  logic [KCNT_W-1:0] kc_r,  kc_nxt;
  logic [VCNT_W-1:0] vc_r,  vc_nxt;
  logic [VCNT_W-1:0] pc_r,  pc_nxt;
  logic              ovf_r, ovf_nxt;
  logic              do_val;
  logic              ws;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_BLANK;
      kc_r  <= '0;
      vc_r  <= '0;
      pc_r  <= '0;
      ovf_r <= 1'b0;
    end else if (acc) begin
      st_r  <= st_nxt;
      kc_r  <= kc_nxt;
      vc_r  <= vc_nxt;
      pc_r  <= pc_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  always_comb begin
    ws      = is_ws(ch);
    st_nxt  = st_r;
    kc_nxt  = kc_r;
    vc_nxt  = vc_r;
    pc_nxt  = pc_r;
    ovf_nxt = ovf_r;
    do_val  = 1'b0;
    step    = '0;
    wr.we   = 1'b0;
    wr.addr = pc_r[PEND_AW-1:0];
    wr.data = ch;

    if (at_end) begin
      case (st_r)
        ST_KEY, ST_SEEK: begin
          step.res_valid = 1'b1;
          step.res_kind  = K_DROP;
        end
        ST_SKIPVAL: begin
          step.res_valid = 1'b1;
          step.res_kind  = K_DONE;
        end
        ST_VALUE: begin
          if (!ovf_r) begin
            step.flush_cnt = pc_r;
          end
          step.res_valid = 1'b1;
          step.res_kind  = K_DONE;
        end
        default: begin
        end
      endcase
      st_nxt  = ST_BLANK;
      kc_nxt  = '0;
      vc_nxt  = '0;
      pc_nxt  = '0;
      ovf_nxt = 1'b0;
    end else begin
      case (st_r)
        ST_COMMENT, ST_IGNORE: begin
          if (ch == CH_NL) begin
            st_nxt = ST_BLANK;
          end
        end
        ST_KEY: begin
          if (ws) begin
            st_nxt = ST_SEEK;
          end else if (ch == CH_EQ) begin
            st_nxt = ST_SKIPVAL;
          end else if (kc_r < KEY_MAX) begin
            step.res_valid = 1'b1;
            step.res_kind  = K_KEY;
            step.res_chr   = ch;
            kc_nxt         = kc_r + 1'b1;
          end else begin
            step.res_valid = 1'b1;
            step.res_kind  = K_DROP;
            st_nxt         = ST_IGNORE;
            kc_nxt         = '0;
            vc_nxt         = '0;
            pc_nxt         = '0;
            ovf_nxt        = 1'b0;
          end
        end
        ST_SEEK: begin
          if (ch == CH_EQ) begin
            st_nxt = ST_SKIPVAL;
          end else if (!ws) begin
            step.res_valid = 1'b1;
            step.res_kind  = K_DROP;
            st_nxt         = ST_IGNORE;
            kc_nxt         = '0;
            vc_nxt         = '0;
            pc_nxt         = '0;
            ovf_nxt        = 1'b0;
          end
        end
        ST_SKIPVAL: begin
          if (!ws) begin
            st_nxt = ST_VALUE;
            do_val = 1'b1;
          end
        end
        ST_VALUE: begin
          if (ch == CH_NL) begin
            step.res_valid = 1'b1;
            step.res_kind  = K_DONE;
            st_nxt         = ST_BLANK;
            kc_nxt         = '0;
            vc_nxt         = '0;
            pc_nxt         = '0;
            ovf_nxt        = 1'b0;
          end else begin
            do_val = 1'b1;
          end
        end
        default: begin
          if (ws) begin
            st_nxt = ST_BLANK;
          end else if (ch == CH_HASH) begin
            st_nxt = ST_COMMENT;
          end else begin
            step.res_valid = 1'b1;
            step.res_kind  = K_KEY;
            step.res_chr   = ch;
            kc_nxt         = KCNT_W'(1);
            st_nxt         = (ch == CH_EQ) ? ST_SEEK : ST_KEY;
          end
        end
      endcase

      if (do_val) begin
        if (vc_r >= VAL_MAX) begin
          ovf_nxt = 1'b1;
        end else if (ws) begin
          wr.we  = acc;
          pc_nxt = pc_r + 1'b1;
          vc_nxt = vc_r + 1'b1;
        end else begin
          step.flush_cnt = pc_r;
          step.res_valid = 1'b1;
          step.res_kind  = K_VAL;
          step.res_chr   = ch;
          vc_nxt         = vc_r + 1'b1;
          pc_nxt         = '0;
        end
      end
    end
  end

endmodule

[sv/kvlp_emit.sv]
// ----------------------------------------------------------------------------
// kvlp_emit
// Result sequencer and output register. Plays out held-back whitespace from
// the pending buffer, one character a cycle while the output is not
// stalled, then the closing result of the request.
// ----------------------------------------------------------------------------
module kvlp_emit
  import kvlp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  step_t              step,
  input  logic [CHAR_W-1:0]  rdata,
  output logic [PEND_AW-1:0] raddr,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output kind_t              out_kind,
  output logic [CHAR_W-1:0]  out_char,
  output logic               out_last
);

  seq_t               seq_r, seq_nxt;
  logic [PEND_AW-1:0] idx_r, idx_nxt;
  logic [VCNT_W-1:0]  cnt_r, cnt_nxt;
  kind_t              tk_r,  tk_nxt;
  logic [CHAR_W-1:0]  tc_r,  tc_nxt;
  logic               ov_r,  ov_nxt;
  kind_t              ok_r,  ok_nxt;
  logic [CHAR_W-1:0]  oc_r,  oc_nxt;
  logic               ol_r,  ol_nxt;
  logic               slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= SEQ_IDLE;
      ov_r  <= 1'b0;
    end else begin
      seq_r <= seq_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    cnt_r <= cnt_nxt;
    tk_r  <= tk_nxt;
    tc_r  <= tc_nxt;
    ok_r  <= ok_nxt;
    oc_r  <= oc_nxt;
    ol_r  <= ol_nxt;
  end

  always_comb begin
    slot_free = !ov_r || !out_stall;
    in_stall  = (seq_r != SEQ_IDLE) || !slot_free;
    seq_nxt   = seq_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    tk_nxt    = tk_r;
    tc_nxt    = tc_r;
    ov_nxt    = ov_r && out_stall;
    ok_nxt    = ok_r;
    oc_nxt    = oc_r;
    ol_nxt    = ol_r;

    case (seq_r)
      SEQ_IDLE: begin
        if (acc) begin
          if (step.flush_cnt != '0) begin
            seq_nxt = SEQ_FLUSH;
            idx_nxt = '0;
            cnt_nxt = step.flush_cnt;
            tk_nxt  = step.res_kind;
            tc_nxt  = step.res_chr;
          end else if (step.res_valid) begin
            ov_nxt = 1'b1;
            ok_nxt = step.res_kind;
            oc_nxt = step.res_chr;
            ol_nxt = 1'b1;
          end
        end
      end
      SEQ_FLUSH: begin
        if (slot_free) begin
          ov_nxt = 1'b1;
          ok_nxt = K_VAL;
          oc_nxt = rdata;
          ol_nxt = 1'b0;
          if ({1'b0, idx_r} == cnt_r - 1'b1) begin
            seq_nxt = SEQ_TAIL;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      SEQ_TAIL: begin
        if (slot_free) begin
          ov_nxt  = 1'b1;
          ok_nxt  = tk_r;
          oc_nxt  = tc_r;
          ol_nxt  = 1'b1;
          seq_nxt = SEQ_IDLE;
        end
      end
      default: begin
        seq_nxt = SEQ_IDLE;
      end
    endcase
  end

  assign raddr     = idx_nxt;
  assign out_valid = ov_r;
  assign out_kind  = ok_r;
  assign out_char  = oc_r;
  assign out_last  = ol_r;

endmodule

[sv/key_value_line_parser.sv]
// While the output is not stalled, one request per cycle is taken if it releases no
// held-back whitespace, and its result is registered in the cycle after acceptance.
// Released whitespace is read one entry per cycle while the output is not stalled, through
// the pending buffer's single registered read port; the input stalls until it and the
// result are out. Reset (synchronous, active low) clears the parser state and the output
// register; the pending buffer is not cleared and is only read below its fill count.
// ----------------------------------------------------------------------------
// key_value_line_parser
// Parses "key = value" lines one character per request and streams key
// characters, value characters and a commit or discard result per record.
// ----------------------------------------------------------------------------
module key_value_line_parser
  import kvlp_pkg::*;
#(
  parameter int unsigned KEY_LEN   = 32,
  parameter int unsigned VALUE_LEN = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] in_ch,
  input  logic              in_at_end,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_kind,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_last
);

  logic               acc;
  step_t              step;
  pwr_t               wr;
  logic [PEND_AW-1:0] raddr;
  logic [CHAR_W-1:0]  rdata;
  kind_t              kind;

  assign acc      = in_valid && !in_stall;
  assign out_kind = kind;

  kvlp_parser #(
    .KEY_LEN   (KEY_LEN),
    .VALUE_LEN (VALUE_LEN)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc    (acc),
    .ch     (in_ch),
    .at_end (in_at_end),
    .step   (step),
    .wr     (wr)
  );

  kvlp_pend_mem u_mem (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  kvlp_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .step      (step),
    .rdata     (rdata),
    .raddr     (raddr),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (kind),
    .out_char  (out_char),
    .out_last  (out_last)
  );

endmodule

[sv/kvlp_checker.sv]
// ----------------------------------------------------------------------------
// kvlp_checker
// Port-level checks for the key/value line parser, bound to the top level.
// ----------------------------------------------------------------------------
module kvlp_checker
  import kvlp_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        out_kind,
  input logic [CHAR_W-1:0] out_char,
  input logic              out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_kind) && $stable(out_char) && $stable(out_last))
    else $error("stalled result changed");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("request taken while output register is blocked");

  a_close_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == K_DONE || out_kind == K_DROP) |-> out_last && (out_char == '0))
    else $error("commit or discard result malformed");

  a_inner_is_space: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |->
      out_kind == K_VAL && (out_char == CH_SP || (out_char >= CH_TAB && out_char <= CH_CR)))
    else $error("non-final result is not held-back whitespace");

endmodule

bind key_value_line_parser kvlp_checker u_kvlp_checker (.*);

[tb/sv/key_value_line_parser_tb.sv]
// ----------------------------------------------------------------------------
// key_value_line_parser_tb
// Feeds character and end-of-file requests to the line parser and checks
// every key character, value character, commit and discard it returns. A
// short table of hand-written requests comes first, then random records,
// comments, broken lines and noise. A behavioral parser in the bench
// predicts the results, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module key_value_line_parser_tb;
  import kvlp_pkg::*;

  localparam int KEY_MAX     = 32;
  localparam int VAL_MAX     = 64;
  localparam int MAX_RESULTS = 64;
  localparam int ITEM_TOTAL  = 310;
  localparam int HOLD_AT     = 60;
  localparam int DRAIN_AT    = 200;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 80;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum {ROW_MODEL, ROW_ONE, ROW_NONE} row_chk_t;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              at_end;
    row_chk_t          chk;
    kind_t             kind;
    logic [CHAR_W-1:0] chr;
  } stim_row_t;

  typedef struct {
    kind_t             kind;
    logic [CHAR_W-1:0] chr;
    logic              last;
  } parse_result_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [CHAR_W-1:0] in_ch;
  logic              in_at_end;
  logic              out_valid;
  logic              out_stall;
  logic [1:0]        out_kind;
  logic [CHAR_W-1:0] out_char;
  logic              out_last;

  parse_result_t     parsed_q[$];
  parse_result_t     step_res[$];
  parse_result_t     oldest_result;
  logic [8:0]        line_q[$];

  pstate_t           kv_state;
  int                kv_key_n;
  int                kv_val_n;
  logic [CHAR_W-1:0] kv_blanks[$];
  bit                kv_overflow;

  int                items_sent = 0;
  int                mismatches = 0;
  int                cycle_count = 0;
  bit                hold_asked = 1'b0;
  bit                hold_served = 1'b0;

  stim_row_t walk [28] = '{
    '{8'h00,   1'b1, ROW_NONE,  K_KEY,  8'h00},
    '{CH_HASH, 1'b0, ROW_NONE,  K_KEY,  8'h00},
    '{8'hff,   1'b0, ROW_NONE,  K_KEY,  8'h00},
    '{CH_NL,   1'b0, ROW_NONE,  K_KEY,  8'h00},
    '{CH_EQ,   1'b0, ROW_ONE,   K_KEY,  CH_EQ},
    '{CH_SP,   1'b0, ROW_NONE,  K_KEY,  8'h00},
    '{CH_EQ,   1'b0, ROW_NONE,  K_KEY,  8'h00},
    '{CH_TAB,  1'b0, ROW_NONE,  K_KEY,  8'h00},
    '{"v",     1'b0, ROW_ONE,   K_VAL,  "v"},
    '{CH_SP,   1'b0, ROW_NONE,  K_KEY,  8'h00},
    '{CH_NL,   1'b0, ROW_ONE,   K_DONE, 8'h00},
    '{8'hff,   1'b0, ROW_ONE,   K_KEY,  8'hff},
    '{8'h00,   1'b0, ROW_ONE,   K_KEY,  8'h00},
    '{CH_CR,   1'b0, ROW_NONE,  K_KEY,  8'h00},
    '{"q",     1'b0, ROW_ONE,   K_DROP, 8'h00},
    '{CH_EQ,   1'b0, ROW_NONE,  K_KEY,  8'h00},
    '{CH_NL,   1'b0, ROW_NONE,  K_KEY,  8'h00},
    '{"a",     1'b0, ROW_ONE,   K_KEY,  "a"},
    '{8'ha5,   1'b1, ROW_ONE,   K_DROP, 8'h00},
    '{"b",     1'b0, ROW_ONE,   K_KEY,  "b"},
    '{CH_EQ,   1'b0, ROW_NONE,  K_KEY,  8'h00},
    '{8'h80,   1'b1, ROW_ONE,   K_DONE, 8'h00},
    '{"k",     1'b0, ROW_MODEL, K_KEY,  8'h00},
    '{CH_EQ,   1'b0, ROW_MODEL, K_KEY,  8'h00},
    '{"x",     1'b0, ROW_MODEL, K_KEY,  8'h00},
    '{CH_SP,   1'b0, ROW_MODEL, K_KEY,  8'h00},
    '{CH_TAB,  1'b0, ROW_MODEL, K_KEY,  8'h00},
    '{8'h7f,   1'b1, ROW_MODEL, K_KEY,  8'h00}
  };

  key_value_line_parser #(
    .KEY_LEN   (KEY_MAX),
    .VALUE_LEN (VAL_MAX)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_ch     (in_ch),
    .in_at_end (in_at_end),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (out_kind),
    .out_char  (out_char),
    .out_last  (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit is_blank(input logic [CHAR_W-1:0] c);
    return (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic void add_result(input kind_t k, input logic [CHAR_W-1:0] c);
    if (step_res.size() < MAX_RESULTS) begin
      step_res.push_back('{k, c, 1'b0});
    end
  endfunction

  function automatic void release_blanks();
    foreach (kv_blanks[i]) add_result(K_VAL, kv_blanks[i]);
    kv_blanks.delete();
  endfunction

  function automatic void restart_record();
    kv_state = ST_BLANK;
    kv_key_n = 0;
    kv_val_n = 0;
    kv_blanks.delete();
    kv_overflow = 1'b0;
  endfunction

  function automatic void take_value_char(input logic [CHAR_W-1:0] c);
    if (kv_val_n >= VAL_MAX - 1) begin
      kv_overflow = 1'b1;
    end else if (is_blank(c)) begin
      kv_blanks.push_back(c);
      kv_val_n++;
    end else begin
      release_blanks();
      add_result(K_VAL, c);
      kv_val_n++;
    end
  endfunction

  function automatic void reject_line();
    add_result(K_DROP, 8'h00);
    restart_record();
    kv_state = ST_IGNORE;
  endfunction

  // Advances the bench's copy of the parser by one request and leaves the
  // results it causes in step_res.
  function automatic void parse_char(input logic [CHAR_W-1:0] c, input logic eof);
    step_res.delete();
    if (eof) begin
      case (kv_state)
        ST_KEY, ST_SEEK: add_result(K_DROP, 8'h00);
        ST_SKIPVAL: add_result(K_DONE, 8'h00);
        ST_VALUE: begin
          if (!kv_overflow) release_blanks();
          add_result(K_DONE, 8'h00);
        end
        default: ;
      endcase
      restart_record();
    end else begin
      case (kv_state)
        ST_COMMENT, ST_IGNORE: begin
          if (c == CH_NL) kv_state = ST_BLANK;
        end
        ST_KEY: begin
          if (is_blank(c)) begin
            kv_state = ST_SEEK;
          end else if (c == CH_EQ) begin
            kv_state = ST_SKIPVAL;
          end else if (kv_key_n < KEY_MAX - 1) begin
            add_result(K_KEY, c);
            kv_key_n++;
          end else begin
            reject_line();
          end
        end
        ST_SEEK: begin
          if (c == CH_EQ) begin
            kv_state = ST_SKIPVAL;
          end else if (!is_blank(c)) begin
            reject_line();
          end
        end
        ST_SKIPVAL: begin
          if (!is_blank(c)) begin
            kv_state = ST_VALUE;
            take_value_char(c);
          end
        end
        ST_VALUE: begin
          if (c == CH_NL) begin
            add_result(K_DONE, 8'h00);
            restart_record();
          end else begin
            take_value_char(c);
          end
        end
        default: begin
          if (is_blank(c)) begin
            kv_state = ST_BLANK;
          end else if (c == CH_HASH) begin
            kv_state = ST_COMMENT;
          end else begin
            add_result(K_KEY, c);
            kv_key_n = 1;
            kv_state = (c == CH_EQ) ? ST_SEEK : ST_KEY;
          end
        end
      endcase
    end
    if (step_res.size() > 0) step_res[step_res.size()-1].last = 1'b1;
  endfunction

  function automatic logic [CHAR_W-1:0] key_byte();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(0, 255));
    while (is_blank(c) || c == CH_EQ || c == CH_HASH);
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] blank_byte(input bit allow_nl);
    int r;
    logic [CHAR_W-1:0] c;
    do begin
      r = $urandom_range(0, 5);
      c = (r == 5) ? CH_SP : CHAR_W'(CH_TAB + r);
    end while (!allow_nl && c == CH_NL);
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] line_byte();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(0, 255));
    while (c == CH_NL);
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] value_byte();
    logic [CHAR_W-1:0] c;
    if ($urandom_range(0, 3) == 0) return blank_byte(1'b0);
    do c = line_byte();
    while (is_blank(c));
    return c;
  endfunction

  function automatic void push_char(input logic [CHAR_W-1:0] c);
    line_q.push_back({1'b0, c});
  endfunction

  function automatic void build_record(input bit long_key, input bit long_val,
                                       input bit eof_end);
    int n;
    if (!long_key && $urandom_range(0, 19) == 0) begin
      push_char(CH_EQ);
    end else begin
      n = long_key ? $urandom_range(KEY_MAX - 3, KEY_MAX + 2) : $urandom_range(1, 6);
      repeat (n) push_char(key_byte());
    end
    repeat ($urandom_range(0, 2)) push_char(blank_byte($urandom_range(0, 4) == 0));
    push_char(CH_EQ);
    repeat ($urandom_range(0, 2)) push_char(blank_byte(1'b1));
    n = long_val ? $urandom_range(VAL_MAX - 6, VAL_MAX + 4) : $urandom_range(0, 8);
    repeat (n) push_char(value_byte());
    repeat ($urandom_range(0, 3)) push_char(blank_byte(1'b0));
    if (eof_end) line_q.push_back({1'b1, 8'($urandom_range(0, 255))});
    else push_char(CH_NL);
  endfunction

  function automatic void flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  task automatic send_request(input logic [CHAR_W-1:0] c, input logic e,
                              input row_chk_t chk, input kind_t tkind,
                              input logic [CHAR_W-1:0] tchar);
    int gap;
    if (items_sent == HOLD_AT) hold_asked = 1'b1;
    if (items_sent == DRAIN_AT) begin
      in_valid <= 1'b0;
      do @(posedge clk);
      while (parsed_q.size() != 0);
    end
    in_valid  <= 1'b1;
    in_ch     <= c;
    in_at_end <= e;
    do @(posedge clk);
    while (in_stall);
    parse_char(c, e);
    if (chk == ROW_MODEL) begin
      foreach (step_res[i]) parsed_q.push_back(step_res[i]);
    end else if (chk == ROW_ONE) begin
      parsed_q.push_back('{tkind, tchar, 1'b1});
    end
    items_sent++;
    if (((items_sent / 50) % 3) == 0 || $urandom_range(0, 4) < 3) gap = 0;
    else gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", parsed_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (parsed_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result kind=%0d char=%02h last=%0b",
                                out_kind, out_char, out_last));
      end else begin
        oldest_result = parsed_q.pop_front();
        if (out_kind !== oldest_result.kind || out_char !== oldest_result.chr ||
            out_last !== oldest_result.last) begin
          flag_mismatch($sformatf(
            "expected kind=%0d char=%02h last=%0b, got kind=%0d char=%02h last=%0b",
            oldest_result.kind, oldest_result.chr, oldest_result.last,
            out_kind, out_char, out_last));
        end
      end
    end
  end

  // The one long hold-off lets the parser back up into its input while the
  // sender keeps offering requests.
  initial begin
    forever begin
      if (hold_asked && !hold_served) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_served = 1'b1;
      end else if (((cycle_count / 400) % 4) == 0) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat (gap_len()) @(posedge clk);
      end
    end
  end

  initial begin
    int rec;
    int pick;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_ch     <= '0;
    in_at_end <= 1'b0;
    restart_record();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (walk[i]) begin
      send_request(walk[i].ch, walk[i].at_end, walk[i].chk, walk[i].kind, walk[i].chr);
    end

    rec = 0;
    while (items_sent < ITEM_TOTAL) begin
      line_q.delete();
      pick = $urandom_range(0, 99);
      if (rec == 0) begin
        build_record(1'b1, 1'b0, 1'b0);
      end else if (rec < 3) begin
        build_record(1'b0, 1'b1, rec == 1);
      end else if (pick < 55) begin
        build_record($urandom_range(0, 19) == 0, $urandom_range(0, 11) == 0,
                     $urandom_range(0, 6) == 0);
      end else if (pick < 65) begin
        repeat ($urandom_range(0, 2)) push_char(blank_byte(1'b1));
        push_char(CH_HASH);
        repeat ($urandom_range(0, 6)) push_char(line_byte());
        push_char(CH_NL);
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 4)) push_char(key_byte());
        push_char(blank_byte(1'b0));
        push_char(key_byte());
        repeat ($urandom_range(0, 4)) push_char(line_byte());
        push_char(CH_NL);
      end else if (pick < 83) begin
        repeat ($urandom_range(1, 4)) push_char(blank_byte(1'b1));
      end else if (pick < 93) begin
        repeat ($urandom_range(1, 8)) begin
          line_q.push_back({1'($urandom_range(0, 7) == 0), 8'($urandom_range(0, 255))});
        end
      end else begin
        line_q.push_back({1'b1, 8'($urandom_range(0, 255))});
      end
      foreach (line_q[i]) send_request(line_q[i][7:0], line_q[i][8], ROW_MODEL, K_KEY, 8'h00);
      rec++;
    end

    in_valid <= 1'b0;
    while (parsed_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && parsed_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
